>>> sv/smf_pkg.sv
// Shared types and constants for the 3x3 switching median filter.
// No dependencies; imported by every module of the block.
package smf_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [15:0] RST_FRAME_HEIGHT = 16'd480;
    localparam logic [7:0]  RST_THRESHOLD    = 8'd25;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

    // pixel code in the kind field
    localparam logic KIND_PIXEL = 1'b0;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } t_out_item;

    // classified window: row-major, index row*3+col, top-left first
    typedef struct packed {
        logic [8:0][7:0] pix;
        logic [8:0]      mask;
        logic            last;
    } t_win_item;

endpackage

>>> sv/smf_front.sv
// Front end: raster counters, two line buffers, 3x3 column window, classification.
// Depends on smf_pkg; pushes windows that yield a result into smf_queue.
module smf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  smf_pkg::t_in_item  i_in_data,
    input  logic [11:0]        i_frame_width,
    input  logic [15:0]        i_frame_height,
    input  logic               i_q_full,
    output logic               o_q_push,
    output smf_pkg::t_win_item o_q_data
);
    import smf_pkg::*;

    typedef struct packed {
        logic             wr;
        logic [COL_W-1:0] col;
        logic [7:0]       pix;
        logic             prod;
        logic [8:0]       mask;
        logic             last;
    } t_s0;

    typedef struct packed {
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] bot;
    } t_column;

    logic [7:0] r_lb_a [MAX_WIDTH];   // row above the newest
    logic [7:0] r_lb_b [MAX_WIDTH];   // two rows above
    logic [7:0] r_rd_a, r_rd_b;

    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [15:0]      r_in_row, n_in_row;
    logic [COL_W-1:0] r_out_c, n_out_c;
    logic [15:0]      r_out_r, n_out_r;
    logic [11:0]      r_lag, n_lag;
    logic             r_all_in, n_all_in;
    logic [11:0]      r_run_w, n_run_w;
    logic [15:0]      r_run_h, n_run_h;
    logic             r_s0_valid;
    t_s0              r_s0, n_s0;
    t_column          r_win [3];
    t_column          new_col;

    logic        accept, s0_adv, start, pix_go, use_item, prod, col_end;
    logic [11:0] w, wm1, cw;
    logic [15:0] h, hm1;
    logic        top_ok, bot_ok, left_ok, right_ok;

    always_comb begin
        cw = (i_frame_width < 12'd2) ? 12'd2 :
             (i_frame_width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : i_frame_width;
    end

    assign s0_adv     = r_s0_valid && (!r_s0.prod || !i_q_full);
    assign o_in_ready = !r_s0_valid || s0_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        start    = (i_in_data.kind == KIND_PIXEL) && (r_in_row == '0) && (r_in_col == '0)
                   && !r_all_in;
        w        = start ? cw : r_run_w;
        h        = start ? ((i_frame_height < 16'd2) ? 16'd2 : i_frame_height) : r_run_h;
        wm1      = w - 12'd1;
        hm1      = h - 16'd1;
        pix_go   = (i_in_data.kind == KIND_PIXEL) && !r_all_in;
        use_item = pix_go || r_all_in;
        prod     = r_all_in || (pix_go && ({1'b0, r_lag} >= ({1'b0, w} + 13'd1)));
        col_end  = ({1'b0, r_in_col} == wm1);
        top_ok   = (r_out_r != '0);
        bot_ok   = (r_out_r != hm1);
        left_ok  = (r_out_c != '0);
        right_ok = ({1'b0, r_out_c} != wm1);

        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_out_c  = r_out_c;
        n_out_r  = r_out_r;
        n_lag    = r_lag;
        n_all_in = r_all_in;
        n_run_w  = start ? cw : r_run_w;
        n_run_h  = h;

        n_s0.wr   = pix_go;
        n_s0.col  = r_in_col;
        n_s0.pix  = i_in_data.pixel_in;
        n_s0.prod = prod;
        n_s0.mask = {bot_ok & right_ok, bot_ok, bot_ok & left_ok,
                     right_ok, 1'b1, left_ok,
                     top_ok & right_ok, top_ok, top_ok & left_ok};
        n_s0.last = prod && (r_out_r == hm1) && ({1'b0, r_out_c} == wm1);

        if (use_item) begin
            n_in_col = col_end ? '0 : r_in_col + 1'b1;
        end
        if (pix_go) begin
            if (col_end) begin
                n_in_row = r_in_row + 16'd1;
                if (r_in_row == hm1) begin
                    n_all_in = 1'b1;
                end
            end
            if (!prod) begin
                n_lag = r_lag + 12'd1;
            end
        end
        if (prod) begin
            if ({1'b0, r_out_c} == wm1) begin
                n_out_c = '0;
                n_out_r = r_out_r + 16'd1;
            end else begin
                n_out_c = r_out_c + 1'b1;
            end
        end
        if (n_s0.last) begin
            n_in_col = '0;
            n_in_row = '0;
            n_out_c  = '0;
            n_out_r  = '0;
            n_lag    = '0;
            n_all_in = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_c    <= '0;
            r_out_r    <= '0;
            r_lag      <= '0;
            r_all_in   <= 1'b0;
            r_run_w    <= 12'd640;
            r_run_h    <= 16'd480;
            r_s0_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
                r_out_c  <= n_out_c;
                r_out_r  <= n_out_r;
                r_lag    <= n_lag;
                r_all_in <= n_all_in;
                r_run_w  <= n_run_w;
                r_run_h  <= n_run_h;
            end
            if (accept && use_item) begin
                r_s0_valid <= 1'b1;
            end else if (s0_adv) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_adv) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= new_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0   <= n_s0;
            r_rd_a <= r_lb_a[r_in_col];
            r_rd_b <= r_lb_b[r_in_col];
        end
        if (s0_adv && r_s0.wr) begin
            r_lb_a[r_s0.col] <= r_s0.pix;
            r_lb_b[r_s0.col] <= r_rd_a;
        end
    end

    assign new_col = '{top: r_rd_b, mid: r_rd_a, bot: r_s0.pix};

    assign o_q_push = s0_adv && r_s0.prod;
    always_comb begin
        o_q_data.pix  = {new_col.bot, r_win[2].bot, r_win[1].bot,
                         new_col.mid, r_win[2].mid, r_win[1].mid,
                         new_col.top, r_win[2].top, r_win[1].top};
        o_q_data.mask = r_s0.mask;
        o_q_data.last = r_s0.last;
    end

endmodule

>>> sv/smf_queue.sv
// Short FIFO of classified windows between front and back end.
// Depends on smf_pkg for the entry type and depth.
module smf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smf_pkg::t_win_item i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output smf_pkg::t_win_item o_data
);
    import smf_pkg::*;

    t_win_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

>>> sv/smf_back.sv
// Back end: rank selection of the median, neighbour mean, switching decision.
// Depends on smf_pkg; two register stages, the second is the output register.
module smf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  smf_pkg::t_win_item i_q_data,
    output logic               o_q_pop,
    input  logic [7:0]         i_threshold,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output smf_pkg::t_out_item o_out_data
);
    import smf_pkg::*;

    logic        r_b1_valid, r_out_valid;
    logic [11:0] r_sum;
    logic [7:0]  r_centre, r_med;
    logic [3:0]  r_n;
    logic        r_last;
    t_out_item   r_out;

    logic        out_load, b1_load;
    logic [11:0] sum;
    logic [3:0]  n, half;
    logic [3:0]  rank [9];
    logic [7:0]  med;

    assign out_load = !r_out_valid || i_out_ready;
    assign b1_load  = !r_b1_valid || out_load;
    assign o_q_pop  = i_q_valid && b1_load;

    // stage 1: count, sum and rank of every window element
    always_comb begin
        sum = '0;
        n   = '0;
        med = i_q_data.pix[4];
        for (int i = 0; i < 9; i++) begin
            if (i_q_data.mask[i]) begin
                sum = sum + 12'(i_q_data.pix[i]);
                n   = n + 4'd1;
            end
        end
        half = n >> 1;
        for (int i = 0; i < 9; i++) begin
            rank[i] = '0;
            for (int j = 0; j < 9; j++) begin
                if (i_q_data.mask[j] && ((i_q_data.pix[j] < i_q_data.pix[i]) ||
                    ((i_q_data.pix[j] == i_q_data.pix[i]) && (j < i)))) begin
                    rank[i] = rank[i] + 4'd1;
                end
            end
        end
        for (int i = 0; i < 9; i++) begin
            if (i_q_data.mask[i] && (rank[i] == half)) med = i_q_data.pix[i];
        end
    end

    // stage 2: mean of the neighbours by shift or by reciprocal multiply
    logic [10:0] nsum;
    logic [15:0] recip;
    logic [26:0] prod;
    logic [7:0]  mean, diff;

    always_comb begin
        nsum  = 11'(r_sum - 12'(r_centre));
        recip = (r_n == 4'd6) ? 16'd52429 : 16'd43691;   // 1/5 and 1/3
        prod  = 27'(nsum) * 27'(recip);
        case (r_n)
            4'd9:    mean = 8'(nsum >> 3);
            4'd6:    mean = 8'(prod >> 18);
            4'd4:    mean = 8'(prod >> 17);
            default: mean = 8'(nsum >> 3);
        endcase
        diff = (mean > r_centre) ? (mean - r_centre) : (r_centre - mean);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b1_load)  r_b1_valid  <= i_q_valid;
            if (out_load) r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sum    <= sum;
            r_centre <= i_q_data.pix[4];
            r_med    <= med;
            r_n      <= n;
            r_last   <= i_q_data.last;
        end
        if (out_load && r_b1_valid) begin
            r_out.pixel_out  <= (diff > i_threshold) ? r_med : r_centre;
            r_out.frame_last <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/switching_median_filter_3x3_unit.sv
// Switching median filter 3x3: one pixel transaction per clock sustained while the output is ready.
// A released result passes r_s0, the queue and both back-end registers; results
// lag the pixel stream by frame_width+1 transactions (flush ticks drain the tail).
// Throughput: 1 per cycle if output ready; each line buffer: one read, one write a cycle.
// Reset: synchronous active low; counters, window and config return to defaults.
module switching_median_filter_3x3_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smf_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smf_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import smf_pkg::*;

    // configuration registers; geometry is latched by the front at frame start
    logic [11:0] r_frame_width;
    logic [15:0] r_frame_height;
    logic [7:0]  r_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_threshold    <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[11:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_THRESHOLD:    r_threshold    <= i_cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // front -> queue -> back
    logic      q_push, q_full, q_pop, q_valid;
    t_win_item q_in, q_out;

    smf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_data       (q_in)
    );

    smf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    smf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .i_threshold (r_threshold),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
